@@ rtl/dense_layer_train_engine_assert.svh @@
// Assertion macros for the dense layer training engine.
// Depends on nothing; included by dlte_ctrl, which checks its own control logic.
`ifndef DENSE_LAYER_TRAIN_ENGINE_ASSERT_SVH
`define DENSE_LAYER_TRAIN_ENGINE_ASSERT_SVH

// Same-cycle implication under an active-low reset
`define DLTE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under an active-low reset
`define DLTE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/dlte_pkg.sv @@
// Shared types for the dense layer training engine: datapath operation codes,
// the controller-to-datapath command word and the status word. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dlte_pkg;

  // Widest row and column counters over the supported size range
  localparam int ROW_W = 12;
  localparam int COL_W = 6;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD_W,
    OP_LOAD_B,
    OP_STORE_X,
    OP_STORE_G,
    OP_RD,
    OP_MUL_FWD,
    OP_ACC_SUM,
    OP_ACC_CLR,
    OP_MUL_BWD,
    OP_ACC_BWD,
    OP_WR_DW,
    OP_MUL_UPD_W,
    OP_WR_W_UPD,
    OP_MUL_UPD_B,
    OP_WR_B_UPD,
    OP_CLR_DW,
    OP_PUSH_FWD,
    OP_PUSH_BWD
  } dp_op_e;

  typedef struct packed {
    dp_op_e             op;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [COL_W-1:0]   col_last;
    logic signed [31:0] value;
    logic [15:0]        lr;
    logic               last;
  } cmd_t;

  typedef struct packed {
    logic push_done;
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/dense_layer_train_engine.sv @@
// Dense layer with SGD training in signed Q16.16. One item is worked on at a
// time. The last forward element also emits one result beat per output
// column, and each backward row emits one result beat. Forward, backward and
// update items are sequenced through the single shared 33x32 multiplier and
// the one read/write port of each weight memory. After reset the
// weight-gradient memory is cleared, during which no item is taken;
// configuration writes are taken at any time.
// Depends on dlte_pkg, dlte_ctrl and dlte_datapath.
`timescale 1ns / 1ps
`default_nettype none

module dense_layer_train_engine #(
  parameter int IN_MAX  = 1024,
  parameter int OUT_MAX = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // index_in[9:0], index_out[13:10], value[45:14]
  input  wire logic [2:0]  s_axis_tuser,   // mode[2:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // result_value[31:0], result_index[41:32]
  output logic             m_axis_tuser,   // result_kind[0]
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  dlte_pkg::cmd_t     cmd;
  dlte_pkg::sts_t     sts;
  logic signed [31:0] res_value;
  logic [9:0]         res_index;

  dlte_ctrl #(
    .IN_MAX (IN_MAX),
    .OUT_MAX(OUT_MAX)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_mode_i     (s_axis_tuser),
    .in_index_in_i (s_axis_tdata[9:0]),
    .in_index_out_i(s_axis_tdata[13:10]),
    .in_value_i    ($signed(s_axis_tdata[45:14])),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_o         (cmd),
    .sts_i         (sts)
  );

  dlte_datapath #(
    .IN_MAX (IN_MAX),
    .OUT_MAX(OUT_MAX)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_value_o(res_value),
    .out_index_o(res_index),
    .out_kind_o (m_axis_tuser),
    .out_last_o (m_axis_tlast)
  );

  // Pack the result beat
  assign m_axis_tdata = {6'd0, res_index, res_value};

endmodule

`default_nettype wire

@@ rtl/dlte_ctrl.sv @@
// Controller of the dense layer training engine: configuration registers, item
// capture and the sequencer that issues datapath commands. Uses dlte_pkg.
`timescale 1ns / 1ps
`default_nettype none

`include "dense_layer_train_engine_assert.svh"

module dlte_ctrl #(
  parameter int IN_MAX  = 1024,
  parameter int OUT_MAX = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [2:0]          in_mode_i,
  input  wire logic [9:0]          in_index_in_i,
  input  wire logic [3:0]          in_index_out_i,
  input  wire logic signed [31:0]  in_value_i,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [15:0]         cfg_data_i,
  output dlte_pkg::cmd_t           cmd_o,
  input  wire dlte_pkg::sts_t      sts_i
);

  localparam int RowW = dlte_pkg::ROW_W;
  localparam int ColW = dlte_pkg::COL_W;

  typedef enum logic [2:0] {
    MODE_LOAD_W   = 3'd0,
    MODE_LOAD_B   = 3'd1,
    MODE_FWD      = 3'd2,
    MODE_GRAD     = 3'd3,
    MODE_BWD      = 3'd4,
    MODE_UPDATE   = 3'd5,
    MODE_CLR_GRAD = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    CFG_IN_COUNT   = 2'd0,
    CFG_OUT_COUNT  = 2'd1,
    CFG_LEARN_RATE = 2'd2
  } cfg_reg_e;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DECODE,
    S_F_RD, S_F_MUL, S_F_ACC, S_F_NEXT, S_F_EMIT,
    S_B_RD, S_B_M1, S_B_ACC, S_B_WR, S_B_NEXT, S_B_EMIT,
    S_U_MUL, S_U_WR, S_U_NEXT, S_UB_WR, S_UB_NEXT
  } state_e;

  state_e             state_q;
  dlte_pkg::cmd_t     cmd_q;
  logic [10:0]        in_cnt_q;
  logic [4:0]         out_cnt_q;
  logic [15:0]        lr_q;
  logic [2:0]         mode_q;
  logic [9:0]         j_q;
  logic [3:0]         o_q;
  logic signed [31:0] val_q;
  logic [RowW-1:0]    row_last;
  logic [ColW-1:0]    col_last;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign cmd_o       = cmd_q;

  // Clamp the configured counts to the storage size
  always_comb begin
    if (in_cnt_q == '0) begin
      row_last = '0;
    end else if (int'(in_cnt_q) > IN_MAX) begin
      row_last = RowW'(IN_MAX - 1);
    end else begin
      row_last = RowW'(in_cnt_q - 11'd1);
    end
    if (out_cnt_q == '0) begin
      col_last = '0;
    end else if (int'(out_cnt_q) > OUT_MAX) begin
      col_last = ColW'(OUT_MAX - 1);
    end else begin
      col_last = ColW'(out_cnt_q - 5'd1);
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cnt_q  <= 11'd784;
      out_cnt_q <= 5'd10;
      lr_q      <= 16'd655;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_IN_COUNT:   in_cnt_q  <= cfg_data_i[10:0];
        CFG_OUT_COUNT:  out_cnt_q <= cfg_data_i[4:0];
        CFG_LEARN_RATE: lr_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Capture the accepted beat
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mode_q <= in_mode_i;
      j_q    <= in_index_in_i;
      o_q    <= in_index_out_i;
      val_q  <= in_value_i;
    end
  end

  // Sequencer: state and the registered command word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cmd_q   <= '{op: dlte_pkg::OP_CLR_DW, default: '0};
    end else begin
      unique case (state_q)
        S_CLEAR: begin
          if (cmd_q.row == RowW'(IN_MAX - 1) && cmd_q.col == ColW'(OUT_MAX - 1)) begin
            cmd_q.op <= dlte_pkg::OP_NOP;
            state_q  <= S_IDLE;
          end else if (cmd_q.col == ColW'(OUT_MAX - 1)) begin
            cmd_q.col <= '0;
            cmd_q.row <= cmd_q.row + 1'b1;
          end else begin
            cmd_q.col <= cmd_q.col + 1'b1;
          end
        end
        S_IDLE: begin
          cmd_q.op <= dlte_pkg::OP_NOP;
          if (in_valid_i) begin
            state_q <= S_DECODE;
          end
        end
        S_DECODE: begin
          cmd_q.row      <= RowW'(j_q);
          cmd_q.col      <= ColW'(o_q);
          cmd_q.value    <= val_q;
          cmd_q.col_last <= col_last;
          cmd_q.lr       <= lr_q;
          cmd_q.last     <= 1'b0;
          cmd_q.op       <= dlte_pkg::OP_NOP;
          state_q        <= S_IDLE;
          unique case (mode_q)
            MODE_LOAD_W: begin
              if (int'(j_q) < IN_MAX && int'(o_q) < OUT_MAX) begin
                cmd_q.op <= dlte_pkg::OP_LOAD_W;
              end
            end
            MODE_LOAD_B: begin
              if (int'(o_q) < OUT_MAX) begin
                cmd_q.op <= dlte_pkg::OP_LOAD_B;
              end
            end
            MODE_FWD: begin
              if (int'(j_q) <= int'(row_last)) begin
                cmd_q.op  <= dlte_pkg::OP_STORE_X;
                cmd_q.col <= '0;
                state_q   <= S_F_RD;
              end
            end
            MODE_GRAD: begin
              if (int'(o_q) <= int'(col_last)) begin
                cmd_q.op <= dlte_pkg::OP_STORE_G;
              end
            end
            MODE_BWD: begin
              if (int'(j_q) <= int'(row_last)) begin
                cmd_q.op  <= dlte_pkg::OP_ACC_CLR;
                cmd_q.col <= '0;
                state_q   <= S_B_RD;
              end
            end
            MODE_UPDATE: begin
              cmd_q.op  <= dlte_pkg::OP_RD;
              cmd_q.row <= '0;
              cmd_q.col <= '0;
              state_q   <= S_U_MUL;
            end
            MODE_CLR_GRAD: begin
              cmd_q.op  <= dlte_pkg::OP_CLR_DW;
              cmd_q.row <= '0;
              cmd_q.col <= '0;
              state_q   <= S_CLEAR;
            end
            default: ;
          endcase
        end
        // Forward: one multiply-accumulate per output column
        S_F_RD: begin
          cmd_q.op <= dlte_pkg::OP_RD;
          state_q  <= S_F_MUL;
        end
        S_F_MUL: begin
          cmd_q.op <= dlte_pkg::OP_MUL_FWD;
          state_q  <= S_F_ACC;
        end
        S_F_ACC: begin
          cmd_q.op <= dlte_pkg::OP_ACC_SUM;
          state_q  <= S_F_NEXT;
        end
        S_F_NEXT: begin
          if (cmd_q.col != cmd_q.col_last) begin
            cmd_q.op  <= dlte_pkg::OP_RD;
            cmd_q.col <= cmd_q.col + 1'b1;
            state_q   <= S_F_MUL;
          end else if (cmd_q.row == row_last) begin
            cmd_q.op   <= dlte_pkg::OP_PUSH_FWD;
            cmd_q.col  <= '0;
            cmd_q.last <= (cmd_q.col_last == '0);
            state_q    <= S_F_EMIT;
          end else begin
            cmd_q.op <= dlte_pkg::OP_NOP;
            state_q  <= S_IDLE;
          end
        end
        S_F_EMIT: begin
          if (sts_i.push_done) begin
            if (cmd_q.col == cmd_q.col_last) begin
              cmd_q.op <= dlte_pkg::OP_NOP;
              state_q  <= S_IDLE;
            end else begin
              cmd_q.col  <= cmd_q.col + 1'b1;
              cmd_q.last <= (cmd_q.col + 1'b1 == cmd_q.col_last);
            end
          end
        end
        // Backward: input gradient and weight gradient per column
        S_B_RD: begin
          cmd_q.op <= dlte_pkg::OP_RD;
          state_q  <= S_B_M1;
        end
        S_B_M1: begin
          cmd_q.op <= dlte_pkg::OP_MUL_BWD;
          state_q  <= S_B_ACC;
        end
        S_B_ACC: begin
          cmd_q.op <= dlte_pkg::OP_ACC_BWD;
          state_q  <= S_B_WR;
        end
        S_B_WR: begin
          cmd_q.op <= dlte_pkg::OP_WR_DW;
          state_q  <= S_B_NEXT;
        end
        S_B_NEXT: begin
          if (cmd_q.col != cmd_q.col_last) begin
            cmd_q.op  <= dlte_pkg::OP_RD;
            cmd_q.col <= cmd_q.col + 1'b1;
            state_q   <= S_B_M1;
          end else begin
            cmd_q.op   <= dlte_pkg::OP_PUSH_BWD;
            cmd_q.last <= (cmd_q.row == row_last);
            state_q    <= S_B_EMIT;
          end
        end
        S_B_EMIT: begin
          if (sts_i.push_done) begin
            cmd_q.op <= dlte_pkg::OP_NOP;
            state_q  <= S_IDLE;
          end
        end
        // Update: sweep the active weights, then the biases
        S_U_MUL: begin
          cmd_q.op <= dlte_pkg::OP_MUL_UPD_W;
          state_q  <= S_U_WR;
        end
        S_U_WR: begin
          cmd_q.op <= dlte_pkg::OP_WR_W_UPD;
          state_q  <= S_U_NEXT;
        end
        S_U_NEXT: begin
          if (cmd_q.col != cmd_q.col_last) begin
            cmd_q.op  <= dlte_pkg::OP_RD;
            cmd_q.col <= cmd_q.col + 1'b1;
            state_q   <= S_U_MUL;
          end else if (cmd_q.row != row_last) begin
            cmd_q.op  <= dlte_pkg::OP_RD;
            cmd_q.col <= '0;
            cmd_q.row <= cmd_q.row + 1'b1;
            state_q   <= S_U_MUL;
          end else begin
            cmd_q.op  <= dlte_pkg::OP_MUL_UPD_B;
            cmd_q.col <= '0;
            state_q   <= S_UB_WR;
          end
        end
        S_UB_WR: begin
          cmd_q.op <= dlte_pkg::OP_WR_B_UPD;
          state_q  <= S_UB_NEXT;
        end
        S_UB_NEXT: begin
          if (cmd_q.col != cmd_q.col_last) begin
            cmd_q.op  <= dlte_pkg::OP_MUL_UPD_B;
            cmd_q.col <= cmd_q.col + 1'b1;
            state_q   <= S_UB_WR;
          end else begin
            cmd_q.op <= dlte_pkg::OP_NOP;
            state_q  <= S_IDLE;
          end
        end
        default: begin
          cmd_q.op <= dlte_pkg::OP_NOP;
          state_q  <= S_IDLE;
        end
      endcase
    end
  end

  `DLTE_ASSERT_NEXT(a_fwd_push_hold, clk_i, rst_ni,
    cmd_q.op == dlte_pkg::OP_PUSH_FWD && !sts_i.push_done,
    cmd_q.op == dlte_pkg::OP_PUSH_FWD && $stable(cmd_q.col), "forward beat dropped")
  `DLTE_ASSERT_NEXT(a_bwd_push_hold, clk_i, rst_ni,
    cmd_q.op == dlte_pkg::OP_PUSH_BWD && !sts_i.push_done,
    cmd_q.op == dlte_pkg::OP_PUSH_BWD && $stable(cmd_q.last), "backward beat dropped")
  `DLTE_ASSERT_IMPL(a_clear_blocks, clk_i, rst_ni, state_q == S_CLEAR,
    !in_ready_o && cmd_q.op == dlte_pkg::OP_CLR_DW, "item taken during clear")
  `DLTE_ASSERT_IMPL(a_col_bound, clk_i, rst_ni, cmd_q.op == dlte_pkg::OP_RD,
    cmd_q.col <= cmd_q.col_last, "column beyond active range")

endmodule

`default_nettype wire

@@ rtl/dlte_datapath.sv @@
// Datapath of the dense layer training engine: weight, gradient and input
// memories, per-column registers, the shared multiplier and the result register.
// Uses dlte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dlte_datapath #(
  parameter int IN_MAX  = 1024,
  parameter int OUT_MAX = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire dlte_pkg::cmd_t  cmd_i,
  output dlte_pkg::sts_t       sts_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic signed [31:0]   out_value_o,
  output logic [9:0]           out_index_o,
  output logic                 out_kind_o,
  output logic                 out_last_o
);

  localparam int Depth = IN_MAX * OUT_MAX;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int RowW  = (IN_MAX > 1) ? $clog2(IN_MAX) : 1;
  localparam int ColW  = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;

  logic signed [31:0] w_mem  [Depth];
  logic signed [31:0] dw_mem [Depth];
  logic signed [31:0] x_mem  [IN_MAX];
  logic signed [31:0] sums_q [OUT_MAX];
  logic signed [31:0] bias_q [OUT_MAX];
  logic signed [31:0] bg_q   [OUT_MAX];
  logic signed [31:0] g_q    [OUT_MAX];

  logic signed [31:0] w_rd_q, dw_rd_q, x_rd_q, acc_q;
  logic signed [63:0] p_q;
  logic signed [63:0] p_sh;
  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [64:0] prod;
  logic               mul_en;
  logic               out_valid_q;
  logic               out_free;
  logic               is_push;
  logic [RowW-1:0]    r;
  logic [ColW-1:0]    c;
  logic [AddrW-1:0]   addr;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  assign r    = cmd_i.row[RowW-1:0];
  assign c    = cmd_i.col[ColW-1:0];
  assign addr = AddrW'(int'(r) * OUT_MAX + int'(c));
  assign p_sh = p_q >>> 16;

  // Result register handshake
  assign out_free  = !out_valid_q || out_ready_i;
  assign is_push   = (cmd_i.op == dlte_pkg::OP_PUSH_FWD) || (cmd_i.op == dlte_pkg::OP_PUSH_BWD);
  assign sts_o.push_done = is_push && out_free;
  assign out_valid_o     = out_valid_q;

  // Select multiplier operands
  always_comb begin
    mul_en = 1'b1;
    unique case (cmd_i.op)
      dlte_pkg::OP_MUL_FWD: begin
        mul_a = 33'(cmd_i.value);
        mul_b = w_rd_q;
      end
      dlte_pkg::OP_MUL_BWD: begin
        mul_a = 33'(g_q[c]);
        mul_b = w_rd_q;
      end
      dlte_pkg::OP_ACC_BWD: begin
        mul_a = 33'(x_rd_q);
        mul_b = g_q[c];
      end
      dlte_pkg::OP_MUL_UPD_W: begin
        mul_a = {17'd0, cmd_i.lr};
        mul_b = dw_rd_q;
      end
      dlte_pkg::OP_MUL_UPD_B: begin
        mul_a = {17'd0, cmd_i.lr};
        mul_b = bg_q[c];
      end
      default: begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Memories, product and payload registers
  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      p_q <= $signed(prod[63:0]);
    end
    unique case (cmd_i.op)
      dlte_pkg::OP_LOAD_W:   w_mem[addr] <= cmd_i.value;
      dlte_pkg::OP_STORE_X:  x_mem[r] <= cmd_i.value;
      dlte_pkg::OP_STORE_G:  g_q[c] <= cmd_i.value;
      dlte_pkg::OP_RD: begin
        w_rd_q  <= w_mem[addr];
        dw_rd_q <= dw_mem[addr];
        x_rd_q  <= x_mem[r];
      end
      dlte_pkg::OP_ACC_CLR:  acc_q <= '0;
      dlte_pkg::OP_ACC_BWD:  acc_q <= sat32(64'(acc_q) + p_sh);
      dlte_pkg::OP_WR_DW:    dw_mem[addr] <= sat32(64'(dw_rd_q) + p_sh);
      dlte_pkg::OP_WR_W_UPD: w_mem[addr] <= sat32(64'(w_rd_q) - p_sh);
      dlte_pkg::OP_CLR_DW:   dw_mem[addr] <= '0;
      default: ;
    endcase
    // Load the result register
    if (cmd_i.op == dlte_pkg::OP_PUSH_FWD && out_free) begin
      out_value_o <= sums_q[c];
      out_index_o <= 10'(cmd_i.col);
      out_kind_o  <= 1'b0;
      out_last_o  <= cmd_i.last;
    end else if (cmd_i.op == dlte_pkg::OP_PUSH_BWD && out_free) begin
      out_value_o <= acc_q;
      out_index_o <= cmd_i.row[9:0];
      out_kind_o  <= 1'b1;
      out_last_o  <= cmd_i.last;
    end
  end

  // Column registers that reset to zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      for (int i = 0; i < OUT_MAX; i++) begin
        sums_q[i] <= '0;
        bias_q[i] <= '0;
        bg_q[i]   <= '0;
      end
    end else begin
      if (is_push && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (cmd_i.op)
        dlte_pkg::OP_LOAD_B:   bias_q[c] <= cmd_i.value;
        dlte_pkg::OP_STORE_X: begin
          // element zero restarts the active sums at their bias
          if (cmd_i.row == '0) begin
            for (int i = 0; i < OUT_MAX; i++) begin
              if (i <= int'(cmd_i.col_last)) begin
                sums_q[i] <= bias_q[i];
              end
            end
          end
        end
        dlte_pkg::OP_STORE_G:  bg_q[c] <= sat32(64'(bg_q[c]) + 64'(cmd_i.value));
        dlte_pkg::OP_ACC_SUM:  sums_q[c] <= sat32(64'(sums_q[c]) + p_sh);
        dlte_pkg::OP_WR_B_UPD: bias_q[c] <= sat32(64'(bias_q[c]) - p_sh);
        dlte_pkg::OP_CLR_DW: begin
          for (int i = 0; i < OUT_MAX; i++) begin
            bg_q[i] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire
